### hdl/aldf_pkg.sv
`default_nettype none
package aldf_pkg;

  // Converter and filter geometry.
  localparam int ADC_BITS    = 10;
  localparam int WINDOW_LOG2 = 3;
  localparam int WIN_LEN     = 1 << WINDOW_LOG2;

  // Field widths fixed by the item format.
  localparam int SAMPLE_W = 10;
  localparam int LEVEL_W  = 4;
  localparam int MODE_W   = 2;
  localparam int LED_W    = 4;

  // Only the low ADC_BITS bits of the sample field take part in the scaling.
  localparam int SAMPLE_USED_W = (ADC_BITS < SAMPLE_W) ? ADC_BITS : SAMPLE_W;
  localparam int PROD_W        = ADC_BITS + LEVEL_W;

  // The running sum of the window never exceeds 15 times the window length.
  localparam int SUM_W = LEVEL_W + WINDOW_LOG2;

  // Thresholds of the summary classes: level/5 clamped to 2.
  localparam logic [LEVEL_W-1:0] CLASS_STEP  = LEVEL_W'(5);
  localparam logic [LEVEL_W-1:0] CLASS_STEP2 = LEVEL_W'(10);

  // One-hot summary class patterns.
  localparam logic [LED_W-1:0] LED_LOW    = LED_W'(1);
  localparam logic [LED_W-1:0] LED_NORMAL = LED_W'(2);
  localparam logic [LED_W-1:0] LED_HIGH   = LED_W'(4);
  localparam logic [LED_W-1:0] LED_BLANK  = '0;

  typedef enum logic [MODE_W-1:0] {
    MODE_NORMAL  = 2'd0,
    MODE_SUMMARY = 2'd1,
    MODE_SLEEP   = 2'd2
  } mode_t;

  typedef struct packed {
    logic                sample_valid;
    logic [SAMPLE_W-1:0] sample;
    logic                timer_due;
    logic                wake_press;
    logic                summary_press;
    logic                summary_release;
    logic                sleep_press;
  } in_item_t;

  typedef struct packed {
    logic [MODE_W-1:0] mode;
    logic [LED_W-1:0]  led_pattern;
    logic              sampling_on;
  } out_item_t;

endpackage
`default_nettype wire

### hdl/aldf_in_if.sv
`default_nettype none
interface aldf_in_if
  import aldf_pkg::*;
;
  logic     valid;
  logic     ready;
  in_item_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface
`default_nettype wire

### hdl/aldf_out_if.sv
`default_nettype none
interface aldf_out_if
  import aldf_pkg::*;
;
  logic      valid;
  logic      ready;
  out_item_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface
`default_nettype wire

### hdl/aldf_avg.sv
`default_nettype none
module aldf_avg
  import aldf_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               push,
  input  wire logic [LEVEL_W-1:0] level,
  output logic      [LED_W-1:0]   avg
);

  logic [LEVEL_W-1:0]     win_r [WIN_LEN];
  logic [WINDOW_LOG2-1:0] pos_r;
  logic [SUM_W-1:0]       sum_r;
  logic [SUM_W-1:0]       sum_nxt;

  // The new level replaces the oldest entry; the sum follows by one add and subtract.
  assign sum_nxt = sum_r + SUM_W'(level) - SUM_W'(win_r[pos_r]);
  assign avg     = sum_nxt[SUM_W-1:WINDOW_LOG2];

  // Window store, write pointer and running sum.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < WIN_LEN; i++) begin
        win_r[i] <= '0;
      end
      pos_r <= '0;
      sum_r <= '0;
    end else if (push) begin
      win_r[pos_r] <= level;
      pos_r        <= pos_r + 1'b1;
      sum_r        <= sum_nxt;
    end
  end

endmodule
`default_nettype wire

### hdl/averaged_level_display_fsm_core.sv
`default_nettype none
// Averaged level display mode machine.
// Each transfer on in_ch is one poll: a converter sample with its valid flag,
// the filter timer tick and the button edges. Each poll gives exactly one
// transfer on out_ch carrying the mode after the poll, the LED pattern and
// the sampling enable.
// A poll passes an input register and a result register, with the mode update,
// level scaling and window update in a single step between them.
// Throughput: one poll per cycle while the receiver does not stall. The limit
// is the state update of the mode machine and the eight-entry averaging window.
// When the receiver stalls, the result stays in the output register and one
// further poll is still taken into the input register; in_ch.ready drops only
// once both registers hold an item.
// Reset puts the block in sleep mode with the LEDs off, the level and the
// averaging window cleared and both registers empty.
module averaged_level_display_fsm_core
  import aldf_pkg::*;
(
  input  wire logic   clk,
  input  wire logic   rst_n,
  aldf_in_if.sink     in_ch,
  aldf_out_if.source  out_ch
);

  in_item_t           in_r;
  logic               in_v_r;
  out_item_t          out_r;
  logic               out_v_r;
  mode_t              mode_r, mode_nxt;
  logic [LEVEL_W-1:0] level_r, level_nxt;
  logic               fresh_r, fresh_nxt;
  logic [LED_W-1:0]   led_r, led_nxt;

  logic               out_free;
  logic               go;
  logic               push;
  logic [LED_W-1:0]   avg;
  logic [PROD_W-1:0]  prod;
  logic [LEVEL_W-1:0] scaled;
  logic [LEVEL_W-1:0] level_cur;
  logic               fresh_cur;
  logic [LED_W-1:0]   class_led;

  // Handshake: the result register frees when empty or taken, the input register follows.
  assign out_free    = !out_v_r || out_ch.ready;
  assign in_ch.ready = !in_v_r || out_free;
  assign go          = in_v_r && out_free;

  // Level scaling: (sample * 15) >> ADC_BITS.
  assign prod   = (PROD_W'(in_r.sample[SAMPLE_USED_W-1:0]) << LEVEL_W)
                - PROD_W'(in_r.sample[SAMPLE_USED_W-1:0]);
  assign scaled = prod[ADC_BITS +: LEVEL_W];

  // The level seen by the filter includes a sample arriving with this poll.
  assign level_cur = in_r.sample_valid ? scaled : level_r;
  assign fresh_cur = in_r.sample_valid || fresh_r;
  assign push      = go && (mode_r == MODE_NORMAL) && fresh_cur && in_r.timer_due;

  // Summary class of the latest level, one-hot.
  always_comb begin
    if (level_r < CLASS_STEP) begin
      class_led = LED_LOW;
    end else if (level_r < CLASS_STEP2) begin
      class_led = LED_NORMAL;
    end else begin
      class_led = LED_HIGH;
    end
  end

  aldf_avg u_avg (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (push),
    .level (level_cur),
    .avg   (avg)
  );

  // Next mode.
  always_comb begin
    mode_nxt = mode_r;
    case (mode_r)
      MODE_NORMAL: begin
        if (in_r.summary_press) begin
          mode_nxt = MODE_SUMMARY;
        end else if (in_r.sleep_press) begin
          mode_nxt = MODE_SLEEP;
        end
      end
      MODE_SUMMARY: begin
        if (in_r.summary_release) begin
          mode_nxt = MODE_NORMAL;
        end
      end
      MODE_SLEEP: begin
        if (in_r.wake_press) begin
          mode_nxt = MODE_NORMAL;
        end
      end
      default: begin
        mode_nxt = in_r.wake_press ? MODE_NORMAL : MODE_SLEEP;
      end
    endcase
  end

  // LED register, latest level and fresh mark.
  always_comb begin
    led_nxt   = led_r;
    level_nxt = level_r;
    fresh_nxt = fresh_r;
    case (mode_r)
      MODE_NORMAL: begin
        level_nxt = level_cur;
        fresh_nxt = fresh_cur && !in_r.timer_due;
        if (fresh_cur && in_r.timer_due) begin
          led_nxt = avg;
        end
        if (in_r.sleep_press) begin
          led_nxt = LED_BLANK;
        end
      end
      MODE_SUMMARY: begin
        led_nxt = in_r.summary_release ? LED_BLANK : class_led;
      end
      MODE_SLEEP: begin
        led_nxt = led_r;
      end
      default: begin
        led_nxt = led_r;
      end
    endcase
  end

  // Input register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_v_r <= 1'b0;
    end else if (in_ch.ready) begin
      in_v_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.ready && in_ch.valid) begin
      in_r <= in_ch.data;
    end
  end

  // Machine state, updated once per poll.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r  <= MODE_SLEEP;
      level_r <= '0;
      fresh_r <= 1'b0;
      led_r   <= LED_BLANK;
    end else if (go) begin
      mode_r  <= mode_nxt;
      level_r <= level_nxt;
      fresh_r <= fresh_nxt;
      led_r   <= led_nxt;
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (out_free) begin
      out_v_r <= in_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (go) begin
      out_r.mode        <= mode_nxt;
      out_r.led_pattern <= led_nxt;
      out_r.sampling_on <= (mode_nxt == MODE_NORMAL);
    end
  end

  assign out_ch.valid = out_v_r;
  assign out_ch.data  = out_r;

  // A buffered poll is never dropped while the result side stalls.
  a_hold_input: assert property (@(posedge clk) disable iff (!rst_n)
    in_v_r && !out_free |=> in_v_r)
    else $error("buffered poll lost during stall");

  // A filter update consumes the fresh level.
  a_fresh_clear: assert property (@(posedge clk) disable iff (!rst_n)
    push |=> !fresh_r)
    else $error("fresh mark survived a filter update");

  // Sleep leaves the LEDs untouched.
  a_sleep_led: assert property (@(posedge clk) disable iff (!rst_n)
    go && (mode_r == MODE_SLEEP) |=> led_r == $past(led_r))
    else $error("LEDs changed in sleep mode");

  // Staying in summary shows exactly one class LED.
  a_summary_onehot: assert property (@(posedge clk) disable iff (!rst_n)
    go && (mode_r == MODE_SUMMARY) && !in_r.summary_release |=> $onehot(led_r))
    else $error("summary pattern not one-hot");

endmodule
`default_nettype wire

### tb/tb_averaged_level_display_fsm_core.sv
`timescale 1ns / 100ps

module tb_averaged_level_display_fsm_core
  import aldf_pkg::*;
;

  // Number of random polls, and the tail of the run that has no idling.
  localparam int unsigned RANDOM_POLLS = 1450;
  localparam int unsigned QUIET_TAIL   = 150;
  // Cycles of settling after the last result, and the long receiver hold-off.
  localparam int unsigned SETTLE_CYCLES = 12;
  localparam int unsigned LONG_HOLD     = 60;
  localparam int unsigned LONG_HOLD_AT  = 400;

  typedef struct {
    in_item_t    poll;
    int unsigned gap;
    bit          drain;
  } poll_entry_t;

  logic clk;
  logic rst_n = 1'b0;

  aldf_in_if  in_ch ();
  aldf_out_if out_ch ();

  // Local copies of the driven channel signals, known from time zero.
  logic     in_valid_q  = 1'b0;
  in_item_t in_poll_q   = '0;
  logic     out_ready_q = 1'b0;

  assign in_ch.valid  = in_valid_q;
  assign in_ch.data   = in_poll_q;
  assign out_ch.ready = out_ready_q;

  averaged_level_display_fsm_core dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  poll_entry_t poll_queue[$];
  out_item_t   expected_displays[$];
  int unsigned polls_sent   = 0;
  int unsigned results_seen = 0;
  int unsigned total_polls  = 0;
  int unsigned errors       = 0;

  // Predicted state of the display machine.
  mode_t             disp_mode    = MODE_SLEEP;
  logic [LEVEL_W-1:0] held_level  = '0;
  bit                level_fresh  = 1'b0;
  logic [LEVEL_W-1:0] level_window [WIN_LEN];
  logic [WINDOW_LOG2-1:0] window_slot = '0;
  logic [SUM_W-1:0]  window_sum   = '0;
  logic [LED_W-1:0]  led_state    = LED_BLANK;

  initial begin
    for (int i = 0; i < WIN_LEN; i++) level_window[i] = '0;
  end

  // Clock generation.
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Advances the predicted machine by one poll and returns the display it shows.
  function automatic out_item_t predict_display(in_item_t p);
    logic [PROD_W-1:0] scaled;
    int unsigned       cls;
    out_item_t         r;
    case (disp_mode)
      MODE_NORMAL: begin
        if (p.sample_valid) begin
          scaled      = PROD_W'(p.sample[SAMPLE_USED_W-1:0]) * PROD_W'(15);
          held_level  = scaled[PROD_W-1:ADC_BITS];
          level_fresh = 1'b1;
        end
        // The timer only pushes a level into the window when one is waiting.
        if (level_fresh && p.timer_due) begin
          level_fresh               = 1'b0;
          window_sum                = window_sum + SUM_W'(held_level)
                                      - SUM_W'(level_window[window_slot]);
          level_window[window_slot] = held_level;
          window_slot               = window_slot + 1'b1;
          led_state                 = LED_W'(window_sum >> WINDOW_LOG2);
        end
        if (p.sleep_press) begin
          led_state = LED_BLANK;
          disp_mode = MODE_SLEEP;
        end
        if (p.summary_press) disp_mode = MODE_SUMMARY;
      end
      MODE_SUMMARY: begin
        cls = held_level / 5;
        if (cls > 2) cls = 2;
        led_state = LED_W'(1) << cls;
        if (p.summary_release) begin
          led_state = LED_BLANK;
          disp_mode = MODE_NORMAL;
        end
      end
      default: begin
        disp_mode = p.wake_press ? MODE_NORMAL : MODE_SLEEP;
      end
    endcase
    r.mode        = disp_mode;
    r.led_pattern = led_state;
    r.sampling_on = (disp_mode == MODE_NORMAL);
    return r;
  endfunction

  function automatic in_item_t mk_poll(bit v, int unsigned s, bit t, bit w, bit sp,
                                       bit sr, bit sl);
    in_item_t p;
    p.sample_valid    = v;
    p.sample          = SAMPLE_W'(s);
    p.timer_due       = t;
    p.wake_press      = w;
    p.summary_press   = sp;
    p.summary_release = sr;
    p.sleep_press     = sl;
    return p;
  endfunction

  function automatic void queue_poll(in_item_t p, int unsigned gap, bit drain);
    poll_entry_t e;
    e.poll  = p;
    e.gap   = gap;
    e.drain = drain;
    poll_queue.push_back(e);
  endfunction

  // Sender: offers queued polls, holding each until its transfer.
  int unsigned in_wait = 0;

  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid_q <= 1'b0;
      in_poll_q  <= '0;
      in_wait    <= 0;
    end else if (in_valid_q && !in_ch.ready) begin
      // Hold the current poll until the block takes it.
    end else if (in_wait != 0) begin
      in_wait    <= in_wait - 1;
      in_valid_q <= 1'b0;
    end else if (poll_queue.size() == 0) begin
      in_valid_q <= 1'b0;
    end else if (poll_queue[0].drain && (in_valid_q || polls_sent != results_seen)) begin
      // Pause until every outstanding result has come back.
      in_valid_q <= 1'b0;
    end else if (poll_queue[0].gap != 0) begin
      in_wait           <= poll_queue[0].gap - 1;
      poll_queue[0].gap  = 0;
      in_valid_q        <= 1'b0;
    end else begin
      in_valid_q <= 1'b1;
      in_poll_q  <= poll_queue[0].poll;
      void'(poll_queue.pop_front());
    end
  end

  // Receiver: random stall bursts, one long hold-off, none near the end.
  int unsigned out_stall      = 0;
  bit          long_hold_done = 1'b0;

  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready_q    <= 1'b0;
      out_stall      <= 0;
      long_hold_done <= 1'b0;
    end else if (out_stall != 0) begin
      out_stall   <= out_stall - 1;
      out_ready_q <= 1'b0;
    end else if (!long_hold_done && results_seen >= LONG_HOLD_AT) begin
      long_hold_done <= 1'b1;
      out_stall      <= LONG_HOLD - 1;
      out_ready_q    <= 1'b0;
    end else if (results_seen + QUIET_TAIL < total_polls && $urandom_range(0, 9) == 0) begin
      out_stall   <= $urandom_range(0, 16);
      out_ready_q <= 1'b0;
    end else begin
      out_ready_q <= 1'b1;
    end
  end

  // Checker: compares each result transfer, then predicts for each poll transfer.
  always @(posedge clk) begin
    out_item_t want;
    if (rst_n) begin
      if (out_ch.valid && out_ready_q) begin
        results_seen <= results_seen + 1;
        if (expected_displays.size() == 0) begin
          errors++;
          $display("%0t: unexpected result, expected none, got %p", $time, out_ch.data);
        end else begin
          want = expected_displays.pop_front();
          if (out_ch.data.mode !== want.mode) begin
            errors++;
            $display("%0t: mode expected %0d, got %0d", $time, want.mode,
                     out_ch.data.mode);
          end
          if (out_ch.data.led_pattern !== want.led_pattern) begin
            errors++;
            $display("%0t: led_pattern expected %b, got %b", $time, want.led_pattern,
                     out_ch.data.led_pattern);
          end
          if (out_ch.data.sampling_on !== want.sampling_on) begin
            errors++;
            $display("%0t: sampling_on expected %0d, got %0d", $time, want.sampling_on,
                     out_ch.data.sampling_on);
          end
        end
      end
      if (in_ch.valid && in_ch.ready) begin
        polls_sent <= polls_sent + 1;
        expected_displays.push_back(predict_display(in_ch.data));
      end
    end
  end

  // Stimulus, reset and end of run.
  initial begin
    in_item_t    p;
    int unsigned gap;
    bit          drain;
    bit          idle_phase;
    int unsigned roll;

    // Directed polls: ignored inputs in sleep, wake, window updates, every
    // summary class, both presses together and a return to sleep.
    queue_poll(mk_poll(1, 1023, 1, 0, 1, 1, 1), 0, 0);
    queue_poll(mk_poll(0, 0, 0, 1, 0, 0, 0), 0, 0);
    queue_poll(mk_poll(1, 1023, 1, 0, 0, 0, 0), 0, 0);
    queue_poll(mk_poll(1, 0, 0, 1, 0, 1, 0), 3, 0);
    queue_poll(mk_poll(0, 0, 1, 0, 0, 0, 0), 0, 0);
    queue_poll(mk_poll(0, 0, 1, 0, 0, 0, 0), 0, 0);
    queue_poll(mk_poll(1, 341, 0, 0, 1, 0, 0), 0, 0);
    queue_poll(mk_poll(1, 1023, 1, 1, 1, 0, 1), 0, 0);
    queue_poll(mk_poll(0, 0, 0, 0, 0, 1, 0), 2, 0);
    queue_poll(mk_poll(1, 342, 1, 0, 0, 0, 0), 0, 0);
    queue_poll(mk_poll(0, 0, 0, 0, 1, 0, 0), 0, 0);
    queue_poll(mk_poll(0, 0, 0, 0, 0, 0, 0), 0, 0);
    queue_poll(mk_poll(0, 0, 0, 0, 0, 1, 0), 0, 0);
    queue_poll(mk_poll(1, 682, 0, 0, 0, 0, 0), 0, 0);
    queue_poll(mk_poll(0, 0, 0, 0, 1, 0, 0), 0, 0);
    queue_poll(mk_poll(0, 0, 0, 0, 0, 0, 0), 0, 0);
    queue_poll(mk_poll(0, 0, 0, 0, 0, 1, 0), 0, 0);
    queue_poll(mk_poll(1, 683, 1, 0, 1, 0, 1), 0, 0);
    queue_poll(mk_poll(0, 0, 0, 0, 0, 0, 0), 0, 0);
    queue_poll(mk_poll(0, 0, 0, 0, 0, 1, 0), 0, 0);
    queue_poll(mk_poll(1, 1023, 1, 0, 0, 0, 1), 0, 0);
    queue_poll(mk_poll(0, 0, 0, 1, 0, 0, 0), 0, 0);

    // Random polls: mostly plausible button traffic, some pure noise.
    for (int unsigned i = 0; i < RANDOM_POLLS; i++) begin
      roll = $urandom_range(0, 99);
      if (roll < 10) begin
        p = in_item_t'($bits(in_item_t)'($urandom));
      end else begin
        p.sample_valid    = ($urandom_range(0, 9) < 6);
        roll              = $urandom_range(0, 9);
        p.sample          = (roll == 0) ? SAMPLE_W'(0) :
                            (roll == 1) ? SAMPLE_W'(1023) : SAMPLE_W'($urandom);
        p.timer_due       = ($urandom_range(0, 9) < 4);
        p.wake_press      = ($urandom_range(0, 9) == 0);
        p.summary_press   = ($urandom_range(0, 99) < 6);
        p.summary_release = ($urandom_range(0, 9) < 2);
        p.sleep_press     = ($urandom_range(0, 99) < 4);
      end
      idle_phase = ((i / 100) % 2 == 0) && (i + QUIET_TAIL < RANDOM_POLLS);
      gap   = (idle_phase && $urandom_range(0, 4) == 0) ? $urandom_range(1, 17) : 0;
      drain = (i == 700) || (i + QUIET_TAIL < RANDOM_POLLS && $urandom_range(0, 249) == 0);
      queue_poll(p, gap, drain);
    end
    total_polls = poll_queue.size();

    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    while (poll_queue.size() != 0 || in_valid_q || polls_sent != results_seen)
      @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);

    if (expected_displays.size() != 0)
      $display("%0t: %0d expected results never arrived", $time, expected_displays.size());
    if (errors == 0 && expected_displays.size() == 0) begin
      $display("tb_averaged_level_display_fsm_core passed");
    end else begin
      $display("tb_averaged_level_display_fsm_core failed");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest correct run.
  initial begin
    #5_000_000;
    $display("tb_averaged_level_display_fsm_core failed");
    $finish;
  end

endmodule
